// File: rtl/pvam_pkg.sv
// Shared types and constants for the priority voice allocator and mixer.
// Used by priority_voice_allocator_mixer and its bench; depends on nothing.
package pvam_pkg;

  localparam int VOICE_COUNT = 4;
  localparam int SOUND_COUNT = 32;
  localparam int LENGTH_BITS = 24;
  localparam int VIDX_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int SAMPLE_PORTS = 4;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = SAMPLE_W + 3;
  localparam int MIX_MAX  = 32767;
  localparam int MIX_MIN  = -32768;
  localparam logic [7:0] PRIO_TOP = 8'd255;

  localparam logic [2:0] ACT_PLAY  = 3'd0;
  localparam logic [2:0] ACT_STOP  = 3'd1;
  localparam logic [2:0] ACT_QUERY = 3'd2;
  localparam logic [2:0] ACT_MIX   = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  typedef struct packed {
    logic [7:0]             sound;
    logic [7:0]             prio;
    logic [LENGTH_BITS-1:0] length;
    logic [LENGTH_BITS-1:0] position;
  } voice_t;

  localparam int VOICE_W = $bits(voice_t);

endpackage

// File: rtl/priority_voice_allocator_mixer.sv
// Four-voice sound-effect allocator and mixer. Voice state (id, priority,
// position, length) sits in one small RAM with a registered read.
// An item is taken only when the block is idle; it then visits every voice
// once, one RAM read a cycle, updating it in place, and a final state forms
// the result and, for an accepted play, writes the chosen voice. The scan
// is paced by the single RAM read port. The result sits in an output
// register, so a stalled result does not block the next transfer in.
// Per-entry valid bits stand in for the reset value, so no clearing pass
// is needed after reset.
// Depends on pvam_pkg and pvam_ram.
module priority_voice_allocator_mixer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [7:0]  sound_id,
  input  logic [7:0]  request_priority,
  input  logic [23:0] effect_length,
  input  logic signed [15:0] music_sample,
  input  logic signed [15:0] voice0_sample,
  input  logic signed [15:0] voice1_sample,
  input  logic signed [15:0] voice2_sample,
  input  logic signed [15:0] voice3_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] mixed_sample,
  output logic [1:0]  chosen_voice,
  output logic        play_accepted,
  output logic        is_playing,
  output logic [3:0]  active_mask
);

  localparam int LB = pvam_pkg::LENGTH_BITS;
  localparam int VW = pvam_pkg::VIDX_W;
  localparam int SW = pvam_pkg::SUM_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state;
  logic [VW-1:0] cnt;

  // latched request
  logic [2:0]    act;
  logic [7:0]    sid;
  logic [7:0]    prio;
  logic [LB-1:0] len;
  logic signed [15:0] samp [pvam_pkg::SAMPLE_PORTS];

  // scan accumulators
  logic          found;
  logic [VW-1:0] found_idx;
  logic [7:0]    min_val;
  logic [VW-1:0] min_pos;
  logic [LB:0]   min_left;
  logic          playing;
  logic signed [SW-1:0] sum;
  logic [3:0]    mask;

  // memory side
  logic [pvam_pkg::VOICE_COUNT-1:0] vld;
  logic          vld_q;
  logic          re;
  logic [VW-1:0] raddr;
  logic [pvam_pkg::VOICE_W-1:0] rdata;
  logic          we;
  logic [VW-1:0] waddr;
  pvam_pkg::voice_t wdata;
  pvam_pkg::voice_t ent;

  logic accept;
  logic id_ok;
  logic out_free;
  logic last;
  logic ent_active;
  logic [LB-1:0] left;
  logic has_port;
  logic signed [15:0] cur_samp;
  logic play_go;
  logic [VW-1:0] play_k;
  logic signed [SW-2:0] half;
  logic signed [15:0] sat;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last     = (cnt == VW'(pvam_pkg::VOICE_COUNT - 1));
  assign id_ok    = ({1'b0, sid} < 9'(pvam_pkg::SOUND_COUNT));

  assign re    = accept || (state == ST_SCAN && !last);
  assign raddr = (state == ST_IDLE) ? '0 : VW'(cnt + 1'b1);

  assign ent        = vld_q ? pvam_pkg::voice_t'(rdata) : '0;
  assign ent_active = ent.position < ent.length;
  assign left       = ent.length - ent.position;
  assign has_port   = (int'(cnt) < pvam_pkg::SAMPLE_PORTS);
  assign cur_samp   = samp[2'(cnt)];

  assign play_go = (act == pvam_pkg::ACT_PLAY) && id_ok && (found || prio >= min_val);
  assign play_k  = found ? found_idx : min_pos;

  // halve toward zero, then clamp
  assign half = (SW-1)'((sum + SW'(sum[SW-1])) >>> 1);
  always_comb begin
    if (half > (SW-1)'(pvam_pkg::MIX_MAX)) begin
      sat = 16'sd32767;
    end else if (half < (SW-1)'(pvam_pkg::MIX_MIN)) begin
      sat = -16'sd32768;
    end else begin
      sat = 16'(half);
    end
  end

  // per-voice write-back during the scan, chosen voice on a play at the end
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = ent;
    if (state == ST_SCAN) begin
      case (act)
        pvam_pkg::ACT_STOP: begin
          if (id_ok && ent.sound == sid) begin
            we             = 1'b1;
            wdata.position = '0;
            wdata.length   = '0;
          end
        end
        pvam_pkg::ACT_CLEAR: begin
          we             = 1'b1;
          wdata.position = '0;
          wdata.length   = '0;
        end
        pvam_pkg::ACT_MIX: begin
          if (ent_active) begin
            we             = 1'b1;
            wdata.position = LB'(ent.position + 1'b1);
          end
        end
        default: ;
      endcase
    end else if (state == ST_FIN && out_free && play_go) begin
      we             = 1'b1;
      waddr          = play_k;
      wdata.sound    = sid;
      wdata.prio     = prio;
      wdata.length   = len;
      wdata.position = '0;
    end
  end

  pvam_ram #(
    .WIDTH(pvam_pkg::VOICE_W),
    .DEPTH(pvam_pkg::VOICE_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
    if (re) begin
      vld_q <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
            cnt   <= '0;
          end
        end
        ST_SCAN: begin
          if (last) begin
            state <= ST_FIN;
          end else begin
            cnt <= VW'(cnt + 1'b1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request latch and scan accumulators
  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= action;
      sid      <= sound_id;
      prio     <= request_priority;
      len      <= effect_length[LB-1:0];
      samp[0]  <= voice0_sample;
      samp[1]  <= voice1_sample;
      samp[2]  <= voice2_sample;
      samp[3]  <= voice3_sample;
      sum      <= SW'(music_sample);
      found    <= 1'b0;
      found_idx <= '0;
      min_val  <= pvam_pkg::PRIO_TOP;
      min_pos  <= '0;
      min_left <= '1;
      playing  <= 1'b0;
      mask     <= '0;
    end else if (state == ST_SCAN) begin
      if (!found) begin
        if (ent.sound == sid || !ent_active) begin
          found     <= 1'b1;
          found_idx <= cnt;
        end else if (ent.prio < min_val) begin
          min_val  <= ent.prio;
          min_pos  <= cnt;
          min_left <= {1'b0, left};
        end else if (ent.prio == min_val && {1'b0, left} < min_left) begin
          min_pos  <= cnt;
          min_left <= {1'b0, left};
        end
      end
      if (id_ok && ent.sound == sid && ent_active) begin
        playing <= 1'b1;
      end
      if (ent_active && has_port) begin
        sum           <= sum + SW'(cur_samp);
        mask[2'(cnt)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      mixed_sample  <= (act == pvam_pkg::ACT_MIX) ? sat : '0;
      active_mask   <= (act == pvam_pkg::ACT_MIX) ? mask : '0;
      is_playing    <= (act == pvam_pkg::ACT_QUERY) && playing;
      play_accepted <= play_go;
      chosen_voice  <= play_go ? 2'(play_k) : '0;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN)
    else $error("transfer in did not start a voice scan");

  a_write_only_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> state != ST_IDLE)
    else $error("voice RAM written while idle");

  a_fin_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && out_valid && out_stall |=> state == ST_FIN)
    else $error("result formed while output register still held");

  a_play_fields_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && play_accepted |-> !is_playing && active_mask == '0 && mixed_sample == '0)
    else $error("play result carries fields of another action");
`endif

endmodule

// File: rtl/pvam_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pvam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: bench/tb_top.sv
// Self-checking bench for priority_voice_allocator_mixer: clocked driver and monitor,
// a voice-state predictor and a queue of expected results.
// Depends on pvam_pkg and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOICE_COUNT = pvam_pkg::VOICE_COUNT;
  localparam int SOUND_COUNT = pvam_pkg::SOUND_COUNT;
  localparam int LENGTH_BITS = pvam_pkg::LENGTH_BITS;
  localparam int MIX_MAX     = pvam_pkg::MIX_MAX;
  localparam int MIX_MIN     = pvam_pkg::MIX_MIN;
  localparam logic [7:0] PRIO_TOP = pvam_pkg::PRIO_TOP;
  localparam logic [2:0] ACT_PLAY  = pvam_pkg::ACT_PLAY;
  localparam logic [2:0] ACT_STOP  = pvam_pkg::ACT_STOP;
  localparam logic [2:0] ACT_QUERY = pvam_pkg::ACT_QUERY;
  localparam logic [2:0] ACT_MIX   = pvam_pkg::ACT_MIX;
  localparam logic [2:0] ACT_CLEAR = pvam_pkg::ACT_CLEAR;
  localparam logic [2:0] ACT_SPARE5 = 3'd5;
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  sound;
    logic [7:0]  prio;
    logic [23:0] len;
    logic [15:0] music;
    logic [15:0] s0;
    logic [15:0] s1;
    logic [15:0] s2;
    logic [15:0] s3;
    logic [3:0]  gap;
  } voice_cmd_t;

  typedef struct packed {
    logic [15:0] mixed;
    logic [1:0]  chosen;
    logic        accepted;
    logic        playing;
    logic [3:0]  mask;
  } voice_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] action = '0;
  logic [7:0] sound_id = '0;
  logic [7:0] request_priority = '0;
  logic [23:0] effect_length = '0;
  logic signed [15:0] music_sample = '0;
  logic signed [15:0] voice0_sample = '0;
  logic signed [15:0] voice1_sample = '0;
  logic signed [15:0] voice2_sample = '0;
  logic signed [15:0] voice3_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] mixed_sample;
  logic [1:0] chosen_voice;
  logic play_accepted;
  logic is_playing;
  logic [3:0] active_mask;

  // predictor copy of the voice table
  logic [LENGTH_BITS-1:0] pv_pos [VOICE_COUNT];
  logic [LENGTH_BITS-1:0] pv_len [VOICE_COUNT];
  logic [7:0]             pv_prio [VOICE_COUNT];
  logic [7:0]             pv_sound [VOICE_COUNT];

  voice_cmd_t    pending_cmds[$];
  voice_result_t expected_results[$];
  voice_cmd_t    cmd_on_bus;

  int  cycle_count = 0;
  int  accepted_count = 0;
  int  result_count = 0;
  int  error_count = 0;
  int  total_cmds = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  bit  rx_hold = 1'b0;

  priority_voice_allocator_mixer u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .sound_id(sound_id), .request_priority(request_priority),
    .effect_length(effect_length), .music_sample(music_sample),
    .voice0_sample(voice0_sample), .voice1_sample(voice1_sample),
    .voice2_sample(voice2_sample), .voice3_sample(voice3_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .mixed_sample(mixed_sample), .chosen_voice(chosen_voice),
    .play_accepted(play_accepted), .is_playing(is_playing),
    .active_mask(active_mask)
  );

  always #4 clk = ~clk;

  function automatic voice_result_t predict_voice_step(voice_cmd_t c);
    voice_result_t r;
    logic signed [15:0] smp [4];
    logic [LENGTH_BITS:0] left;
    logic [LENGTH_BITS:0] min_left;
    logic [7:0] min_prio;
    int  pick;
    int  sum;
    bit  found;
    r = '0;
    smp[0] = c.s0;
    smp[1] = c.s1;
    smp[2] = c.s2;
    smp[3] = c.s3;
    case (c.action)
      ACT_PLAY: begin
        if (int'(c.sound) < SOUND_COUNT) begin
          found = 1'b0;
          pick = 0;
          min_prio = PRIO_TOP;
          min_left = '1;
          for (int k = 0; k < VOICE_COUNT; k++) begin
            if (!found) begin
              if (pv_sound[k] == c.sound || !(pv_pos[k] < pv_len[k])) begin
                found = 1'b1;
                pick = k;
              end else begin
                left = {1'b0, pv_len[k] - pv_pos[k]};
                if (pv_prio[k] < min_prio) begin
                  min_prio = pv_prio[k];
                  pick = k;
                  min_left = left;
                end else if (pv_prio[k] == min_prio && left < min_left) begin
                  pick = k;
                  min_left = left;
                end
              end
            end
          end
          // refused when every voice is busy and outranks the request
          if (found || c.prio >= min_prio) begin
            pv_len[pick] = c.len;
            pv_pos[pick] = '0;
            pv_prio[pick] = c.prio;
            pv_sound[pick] = c.sound;
            r.chosen = pick[1:0];
            r.accepted = 1'b1;
          end
        end
      end
      ACT_STOP: begin
        if (int'(c.sound) < SOUND_COUNT) begin
          for (int k = 0; k < VOICE_COUNT; k++) begin
            if (pv_sound[k] == c.sound) begin
              pv_pos[k] = '0;
              pv_len[k] = '0;
            end
          end
        end
      end
      ACT_QUERY: begin
        if (int'(c.sound) < SOUND_COUNT) begin
          for (int k = 0; k < VOICE_COUNT; k++) begin
            if (pv_sound[k] == c.sound && pv_pos[k] < pv_len[k]) r.playing = 1'b1;
          end
        end
      end
      ACT_MIX: begin
        sum = int'($signed(c.music));
        for (int k = 0; k < VOICE_COUNT; k++) begin
          if (pv_pos[k] < pv_len[k]) begin
            if (k < 4) begin
              sum += int'(smp[k]);
              r.mask[k] = 1'b1;
            end
            pv_pos[k] = pv_pos[k] + 1'b1;
          end
        end
        sum = sum / 2;  // truncates toward zero
        if (sum > MIX_MAX) sum = MIX_MAX;
        if (sum < MIX_MIN) sum = MIX_MIN;
        r.mixed = sum[15:0];
      end
      ACT_CLEAR: begin
        for (int k = 0; k < VOICE_COUNT; k++) begin
          pv_pos[k] = '0;
          pv_len[k] = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("result %0d: %s is %0d, expected %0d", result_count, what, got, want);
    error_count++;
  endtask

  task automatic add_cmd(logic [2:0] act, logic [7:0] id, logic [7:0] prio, logic [23:0] len,
                         logic [15:0] music, logic [15:0] a, logic [15:0] b,
                         logic [15:0] c, logic [15:0] d, int gap);
    voice_cmd_t cmd;
    cmd = '{act, id, prio, len, music, a, b, c, d, gap[3:0]};
    pending_cmds.push_back(cmd);
  endtask

  function automatic logic [15:0] rand_sample();
    return 16'($urandom_range(0, 65535));
  endfunction

  // driver: a stalled transfer keeps its payload; the gap comes before each item
  always @(negedge clk) begin
    voice_cmd_t c;
    logic nxt_valid;
    nxt_valid = in_valid;
    if (!rst && !(in_valid && !in_taken)) begin
      if (in_taken) begin
        in_taken = 1'b0;
        gap_left = (pending_cmds.size() != 0) ? int'(pending_cmds[0].gap) : 0;
      end
      if (gap_left != 0) begin
        gap_left--;
        nxt_valid = 1'b0;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        cmd_on_bus = c;
        action <= c.action;
        sound_id <= c.sound;
        request_priority <= c.prio;
        effect_length <= c.len;
        music_sample <= c.music;
        voice0_sample <= c.s0;
        voice1_sample <= c.s1;
        voice2_sample <= c.s2;
        voice3_sample <= c.s3;
        nxt_valid = 1'b1;
      end else begin
        nxt_valid = 1'b0;
      end
    end
    in_valid <= nxt_valid;
  end

  // receiver: random stall after each transfer, quiet stretches, one long hold
  always @(negedge clk) begin
    logic nxt_stall;
    if (out_taken) begin
      out_taken = 1'b0;
      stall_left = (((result_count / 150) % 4) == 3) ? 0 : int'($urandom_range(0, 9));
    end
    nxt_stall = rx_hold || (stall_left != 0);
    if (stall_left != 0) stall_left--;
    out_stall <= nxt_stall;
  end

  always @(posedge clk) begin
    voice_result_t want;
    voice_result_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end else if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_voice_step(cmd_on_bus));
        in_taken = 1'b1;
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        got = '{mixed_sample, chosen_voice, play_accepted, is_playing, active_mask};
        out_taken = 1'b1;
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer, mixed_sample",
                          int'($signed(got.mixed)), 0);
        end else begin
          want = expected_results.pop_front();
          if (got.mixed !== want.mixed)
            report_mismatch("mixed_sample", int'($signed(got.mixed)),
                            int'($signed(want.mixed)));
          if (got.chosen !== want.chosen)
            report_mismatch("chosen_voice", int'(got.chosen), int'(want.chosen));
          if (got.accepted !== want.accepted)
            report_mismatch("play_accepted", int'(got.accepted), int'(want.accepted));
          if (got.playing !== want.playing)
            report_mismatch("is_playing", int'(got.playing), int'(want.playing));
          if (got.mask !== want.mask)
            report_mismatch("active_mask", int'(got.mask), int'(want.mask));
        end
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (accepted_count >= 300);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    int r;
    int gap;
    logic [2:0]  act;
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [23:0] len;
    for (int k = 0; k < VOICE_COUNT; k++) begin
      pv_pos[k] = '0;
      pv_len[k] = '0;
      pv_prio[k] = '0;
      pv_sound[k] = '0;
    end

    // directed part
    add_cmd(ACT_QUERY, 8'd0, 8'd0, 24'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    add_cmd(ACT_PLAY, 8'd5, 8'd10, 24'd3, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1);
    add_cmd(ACT_PLAY, 8'd6, 8'd20, 24'd100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    add_cmd(ACT_PLAY, 8'd7, 8'd20, 24'd50, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 2);
    add_cmd(ACT_PLAY, 8'd31, 8'd255, 24'hFFFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    // all busy: below lowest priority is refused, equal steals
    add_cmd(ACT_PLAY, 8'd8, 8'd5, 24'd10, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    add_cmd(ACT_PLAY, 8'd9, 8'd10, 24'd10, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 3);
    // saturation both ways, then truncation toward zero
    add_cmd(ACT_MIX, 8'hFF, 8'hFF, 24'hFFFFFF,
            16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    add_cmd(ACT_MIX, 8'h00, 8'h00, 24'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    add_cmd(ACT_MIX, 8'h00, 8'h00, 24'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 5);
    // same id restarts its voice; then a tie on priority goes to fewest words left
    add_cmd(ACT_PLAY, 8'd9, 8'd200, 24'd4, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    add_cmd(ACT_PLAY, 8'd12, 8'd20, 24'd7, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    add_cmd(ACT_QUERY, 8'd9, 8'd0, 24'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    add_cmd(ACT_QUERY, 8'd8, 8'd0, 24'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 9);
    add_cmd(ACT_STOP, 8'd9, 8'd0, 24'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    add_cmd(ACT_QUERY, 8'd9, 8'd0, 24'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    // ids out of range are ignored
    add_cmd(ACT_PLAY, 8'd32, 8'd255, 24'd5, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    add_cmd(ACT_PLAY, 8'd255, 8'd255, 24'hFFFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    add_cmd(ACT_STOP, 8'd255, 8'd0, 24'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    add_cmd(ACT_QUERY, 8'd200, 8'd0, 24'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    // unused actions with every field bit set
    add_cmd(ACT_SPARE5, 8'hFF, 8'hFF, 24'hFFFFFF,
            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    add_cmd(ACT_SPARE6, 8'hFF, 8'hFF, 24'hFFFFFF,
            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    add_cmd(ACT_SPARE7, 8'hFF, 8'hFF, 24'hFFFFFF,
            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4);
    // zero-length play on a finished voice, then clear
    add_cmd(ACT_PLAY, 8'd3, 8'd0, 24'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    add_cmd(ACT_CLEAR, 8'd0, 8'd0, 24'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    add_cmd(ACT_MIX, 8'd0, 8'd0, 24'd0, 16'h1235, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    add_cmd(ACT_QUERY, 8'd31, 8'd0, 24'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);

    // random part: small id pool and short effects keep voices busy and turning over
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = int'($urandom_range(0, 99));
      if (r < 36) act = ACT_PLAY;
      else if (r < 74) act = ACT_MIX;
      else if (r < 82) act = ACT_STOP;
      else if (r < 94) act = ACT_QUERY;
      else if (r < 97) act = ACT_CLEAR;
      else act = 3'($urandom_range(ACT_SPARE5, ACT_SPARE7));
      r = int'($urandom_range(0, 99));
      if (r < 85) id = 8'($urandom_range(0, 11));
      else if (r < 95) id = 8'($urandom_range(0, 35));
      else id = 8'($urandom_range(0, 255));
      r = int'($urandom_range(0, 99));
      if (r < 45) prio = 8'($urandom_range(0, 3));
      else if (r < 50) prio = PRIO_TOP;
      else prio = 8'($urandom_range(0, 255));
      r = int'($urandom_range(0, 99));
      if (r < 80) len = 24'($urandom_range(0, 24));
      else if (r < 95) len = 24'($urandom_range(0, 300));
      else if (r < 97) len = 24'hFFFFFF;
      else len = 24'($urandom_range(0, 24'hFFFFFF));
      gap = (((i / 120) % 5) == 4) ? 0 : int'($urandom_range(0, 9));
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1)
          add_cmd(act, id, prio, len, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, gap);
        else
          add_cmd(act, id, prio, len, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, gap);
      end else begin
        add_cmd(act, id, prio, len, rand_sample(), rand_sample(), rand_sample(),
                rand_sample(), rand_sample(), gap);
      end
    end
    total_cmds = pending_cmds.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (accepted_count == total_cmds);
    wait (expected_results.size() == 0);
    // leave room for any stray transfer
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
